/* hdl/mmse_pkg.sv */
// shared constants for the adaptive local-statistics noise filter
// register indexes, field widths and size limits; no dependencies
`default_nettype none

package mmse_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_WINDOW = 7;
  localparam int PIXEL_BITS = 8;

  localparam int CFG_AW     = 2;
  localparam int DIM_W      = 11;
  localparam int WIN_W      = 3;
  localparam int HALF_W     = 2;
  localparam int NOISE_W    = 24;
  localparam int CNT_W      = 6;   // window pixel count up to 7*7
  localparam int LIN_W      = 22;

  localparam logic [CFG_AW-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_WINDOW = 2'd2;
  localparam logic [CFG_AW-1:0] REG_NOISE  = 2'd3;

  localparam logic [DIM_W-1:0]   WIDTH_RST  = 11'd1024;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 11'd1024;
  localparam logic [WIN_W-1:0]   WINDOW_RST = 3'd3;
  localparam logic [NOISE_W-1:0] NOISE_RST  = 24'd0;

endpackage

`default_nettype wire

/* hdl/mmse_line_mem.sv */
// line store: single write port, single registered read port
// no dependencies
`default_nettype none

module mmse_line_mem #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/mmse_div.sv */
// restoring divider, one quotient bit per cycle, quotient known to fit QW bits
// no dependencies
`default_nettype none

module mmse_div #(
  parameter int NUMW = 51,
  parameter int DENW = 42,
  parameter int QW   = 9
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [NUMW-1:0] num,
  input  wire logic [DENW-1:0] den,
  output logic                 done,
  output logic      [QW-1:0]   quo
);

  localparam int KW = (QW > 1) ? $clog2(QW) : 1;

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [NUMW-1:0] rem_r, rem_nxt;
  logic [DENW-1:0] den_r, den_nxt;
  logic [QW-1:0]   quo_r, quo_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic [NUMW-1:0] trial;

  assign trial = NUMW'(den_r) << k_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    k_nxt    = k_r;
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = num;
      den_nxt  = den;
      quo_nxt  = '0;
      k_nxt    = KW'(QW - 1);
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt     = rem_r - trial;
        quo_nxt[k_r] = 1'b1;
      end
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
    k_r   <= k_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

/* hdl/mmse_adaptive_noise_filter_unit.sv */
// top level of the adaptive local-statistics noise filter
// uses mmse_pkg, mmse_line_mem and mmse_div
//
//  channel | direction | signals                               | transaction
//  in_     | slave     | tvalid tready tdata tuser             | one pixel or flush step
//  out_    | master    | tvalid tready tdata tlast tuser       | one filtered pixel
//  cfg_    | slave     | valid ready addr data                 | one register write
//
// items are taken one at a time; a flush with no frame active goes back to idle; a border
// pixel, or any pixel with zero noise, passes its centre value through; an interior pixel
// walks its win*win window over the single read port of the line store and then runs the
// bit-serial divider, on window sum over pixel count when the ratio clamps to one;
// reset (rst_n low, synchronous) clears the control state; the line store is not cleared
// a result waiting in the output register lets the next item in; only the
// hand-over of a new result waits for out_tready
`default_nettype none

module mmse_adaptive_noise_filter_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,   // [7:0] pixel_in
  input  wire logic [0:0]                  in_tuser,   // [0] command
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [7:0]                  out_tdata,  // [7:0] pixel_out
  output logic                             out_tlast,  // frame_end
  output logic      [0:0]                  out_tuser,  // [0] config_error
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [mmse_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [23:0]                 cfg_data
);

  import mmse_pkg::*;

  localparam int PB   = PIXEL_BITS;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int SLW  = $clog2(MAX_WINDOW);
  localparam int MAW  = SLW + CW;
  localparam int MDEP = MAX_WINDOW << CW;
  localparam int SW   = PB + CNT_W;
  localparam int QSW  = 2 * PB + CNT_W;
  localparam int DW   = QSW + CNT_W;
  localparam int AW   = NOISE_W + 2 * CNT_W;
  localparam int BW   = DW + 8;
  localparam int NBW  = BW + CNT_W;
  localparam int NUMW = NBW + PB + 1;
  localparam int QW   = PB + 1;
  localparam int CMPW = (AW > BW) ? AW : BW;
  localparam logic [PB-1:0] PIX_MAX = {PB{1'b1}};

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_START  = 5'd1;
  localparam logic [4:0] S_PREP   = 5'd2;
  localparam logic [4:0] S_WRITE  = 5'd3;
  localparam logic [4:0] S_DECIDE = 5'd4;
  localparam logic [4:0] S_RDC    = 5'd5;
  localparam logic [4:0] S_CEN    = 5'd6;
  localparam logic [4:0] S_WIN    = 5'd7;
  localparam logic [4:0] S_WTAIL  = 5'd8;
  localparam logic [4:0] S_A0     = 5'd9;
  localparam logic [4:0] S_A1     = 5'd10;
  localparam logic [4:0] S_A2     = 5'd11;
  localparam logic [4:0] S_A3     = 5'd12;
  localparam logic [4:0] S_A4     = 5'd13;
  localparam logic [4:0] S_A5     = 5'd14;
  localparam logic [4:0] S_A6     = 5'd15;
  localparam logic [4:0] S_A7     = 5'd16;
  localparam logic [4:0] S_DIVW   = 5'd17;
  localparam logic [4:0] S_EMIT   = 5'd18;

  logic [4:0] state_r, state_nxt;

  // configuration registers
  logic [DIM_W-1:0]   cfg_width_r, cfg_height_r;
  logic [WIN_W-1:0]   cfg_win_r;
  logic [NOISE_W-1:0] cfg_noise_r;

  // item and frame
  logic               flush_r, flush_nxt;
  logic [7:0]         px_r, px_nxt;
  logic               active_r, active_nxt;
  logic [DIM_W-1:0]   fw_r, fw_nxt, fh_r, fh_nxt;
  logic [WIN_W-1:0]   fwin_r, fwin_nxt;
  logic [HALF_W-1:0]  fhalf_r, fhalf_nxt;
  logic [NOISE_W-1:0] fnoise_r, fnoise_nxt;
  logic               ferr_r, ferr_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [LIN_W-1:0]   total_r, total_nxt, lag_r, lag_nxt;

  // counters
  logic [DIM_W-1:0]   col_r, col_nxt, orow_r, orow_nxt, ocol_r, ocol_nxt;
  logic [SLW-1:0]     in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic [LIN_W-1:0]   in_lin_r, in_lin_nxt, out_lin_r, out_lin_nxt;

  // window walk and statistics
  logic               border_r, border_nxt;
  logic [WIN_W-1:0]   wi_r, wi_nxt, wj_r, wj_nxt;
  logic [SLW-1:0]     wslot_r, wslot_nxt;
  logic               rd_v_r;
  logic [SW-1:0]      s_r, s_nxt;
  logic [QSW-1:0]     q_r, q_nxt;
  logic [PB-1:0]      c_r, c_nxt;

  // arithmetic
  logic [DW-1:0]      nq_r, nq_nxt, ss_r, ss_nxt, d_r, d_nxt;
  logic [AW-1:0]      anv_r, anv_nxt, a_r, a_nxt;
  logic [SW-1:0]      nc_r, nc_nxt, diff_r, diff_nxt;
  logic               pos_r, pos_nxt;
  logic [BW-1:0]      b_r, b_nxt;
  logic [NBW-1:0]     nb_r, nb_nxt;
  logic [NUMW-1:0]    cnb_r, cnb_nxt, adiff_r, adiff_nxt;
  logic [PB-1:0]      res_r, res_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_pix_r, out_pix_nxt;
  logic               out_last_r, out_last_nxt, out_err_r, out_err_nxt;

  // memory and divider
  logic               mem_we;
  logic [MAW-1:0]     mem_waddr, mem_raddr;
  logic [PB-1:0]      mem_rdata;
  logic               div_start, div_done;
  logic [NUMW-1:0]    div_num;
  logic [NBW-1:0]     div_den;
  logic [QW-1:0]      div_quo;

  // frame start values
  logic [DIM_W-1:0]   st_fw, st_fh;
  logic               st_err;
  logic [DIM_W-1:0]   wcol;
  logic [SLW-1:0]     start_slot;

  mmse_line_mem #(.DEPTH(MDEP), .AW(MAW), .DW(PB)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (PB'(px_r)),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mmse_div #(.NUMW(NUMW), .DENW(NBW), .QW(QW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= WIDTH_RST;
      cfg_height_r <= HEIGHT_RST;
      cfg_win_r    <= WINDOW_RST;
      cfg_noise_r  <= NOISE_RST;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_WIDTH:  cfg_width_r  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: cfg_height_r <= cfg_data[DIM_W-1:0];
        REG_WINDOW: cfg_win_r    <= cfg_data[WIN_W-1:0];
        REG_NOISE:  cfg_noise_r  <= cfg_data[NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_width_r == '0) begin
      st_fw = DIM_W'(1);
    end else if (int'(cfg_width_r) > MAX_WIDTH) begin
      st_fw = DIM_W'(MAX_WIDTH);
    end else begin
      st_fw = cfg_width_r;
    end
    st_fh  = (cfg_height_r == '0) ? DIM_W'(1) : cfg_height_r;
    st_err = !cfg_win_r[0] || (int'(cfg_win_r) > MAX_WINDOW) ||
             (DIM_W'(cfg_win_r) > st_fw) || (DIM_W'(cfg_win_r) > st_fh);
  end

  assign wcol = ocol_r - DIM_W'(fhalf_r) + DIM_W'(wj_r);
  assign start_slot = (out_slot_r >= SLW'(fhalf_r)) ? (out_slot_r - SLW'(fhalf_r)) :
                      SLW'(int'(out_slot_r) + MAX_WINDOW - int'(fhalf_r));

  always_comb begin
    mem_we    = (state_r == S_WRITE) && !flush_r && (in_lin_r < total_r);
    mem_waddr = {in_slot_r, CW'(col_r)};
    if (state_r == S_WIN) begin
      mem_raddr = {wslot_r, CW'(wcol)};
    end else begin
      mem_raddr = {out_slot_r, CW'(ocol_r)};
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = NUMW'(s_r);
    div_den   = NBW'(n_r);
    if (state_r == S_A5 && ((d_r == '0) || (CMPW'(a_r) >= CMPW'(b_r)))) begin
      div_start = 1'b1;
    end else if (state_r == S_A7) begin
      div_start = 1'b1;
      div_num   = pos_r ? (cnb_r + adiff_r) : (cnb_r - adiff_r);
      div_den   = nb_r;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    flush_nxt    = flush_r;
    px_nxt       = px_r;
    active_nxt   = active_r;
    fw_nxt       = fw_r;
    fh_nxt       = fh_r;
    fwin_nxt     = fwin_r;
    fhalf_nxt    = fhalf_r;
    fnoise_nxt   = fnoise_r;
    ferr_nxt     = ferr_r;
    n_nxt        = n_r;
    total_nxt    = total_r;
    lag_nxt      = lag_r;
    col_nxt      = col_r;
    orow_nxt     = orow_r;
    ocol_nxt     = ocol_r;
    in_slot_nxt  = in_slot_r;
    out_slot_nxt = out_slot_r;
    in_lin_nxt   = in_lin_r;
    out_lin_nxt  = out_lin_r;
    border_nxt   = border_r;
    wi_nxt       = wi_r;
    wj_nxt       = wj_r;
    wslot_nxt    = wslot_r;
    s_nxt        = s_r;
    q_nxt        = q_r;
    c_nxt        = c_r;
    nq_nxt       = nq_r;
    ss_nxt       = ss_r;
    d_nxt        = d_r;
    anv_nxt      = anv_r;
    a_nxt        = a_r;
    nc_nxt       = nc_r;
    diff_nxt     = diff_r;
    pos_nxt      = pos_r;
    b_nxt        = b_r;
    nb_nxt       = nb_r;
    cnb_nxt      = cnb_r;
    adiff_nxt    = adiff_r;
    res_nxt      = res_r;
    out_pix_nxt  = out_pix_r;
    out_last_nxt = out_last_r;
    out_err_nxt  = out_err_r;
    out_valid_nxt = out_valid_r && !out_tready;

    // window accumulation follows the registered read, in the cycle after its address
    if (rd_v_r) begin
      s_nxt = s_r + SW'(mem_rdata);
      q_nxt = q_r + QSW'(QSW'(mem_rdata) * QSW'(mem_rdata));
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          flush_nxt = in_tuser[0];
          px_nxt    = in_tdata;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (active_r) begin
          state_nxt = S_WRITE;
        end else if (flush_r) begin
          state_nxt = S_IDLE;
        end else begin
          active_nxt   = 1'b1;
          fw_nxt       = st_fw;
          fh_nxt       = st_fh;
          ferr_nxt     = st_err;
          fwin_nxt     = st_err ? WIN_W'(1) : cfg_win_r;
          fhalf_nxt    = st_err ? '0 : HALF_W'(cfg_win_r >> 1);
          fnoise_nxt   = cfg_noise_r;
          col_nxt      = '0;
          orow_nxt     = '0;
          ocol_nxt     = '0;
          in_slot_nxt  = '0;
          out_slot_nxt = '0;
          in_lin_nxt   = '0;
          out_lin_nxt  = '0;
          state_nxt    = S_PREP;
        end
      end
      S_PREP: begin
        total_nxt = LIN_W'(fw_r) * LIN_W'(fh_r);
        lag_nxt   = LIN_W'(fhalf_r) * LIN_W'(fw_r) + LIN_W'(fhalf_r);
        n_nxt     = CNT_W'(fwin_r) * CNT_W'(fwin_r);
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (mem_we) begin
          in_lin_nxt = in_lin_r + 1'b1;
          if (col_r + 1'b1 >= fw_r) begin
            col_nxt     = '0;
            in_slot_nxt = (int'(in_slot_r) == MAX_WINDOW - 1) ? '0 : in_slot_r + 1'b1;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if ((in_lin_r == total_r) || (in_lin_r > out_lin_r + lag_r)) begin
          border_nxt = (fhalf_r == '0) || (orow_r < DIM_W'(fhalf_r)) ||
                       (ocol_r < DIM_W'(fhalf_r)) ||
                       (orow_r + DIM_W'(fhalf_r) >= fh_r) ||
                       (ocol_r + DIM_W'(fhalf_r) >= fw_r);
          state_nxt = S_RDC;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RDC: begin
        state_nxt = S_CEN;
      end
      S_CEN: begin
        c_nxt = mem_rdata;
        if (border_r || fnoise_r == '0) begin
          res_nxt   = mem_rdata;
          state_nxt = S_EMIT;
        end else begin
          wi_nxt    = '0;
          wj_nxt    = '0;
          wslot_nxt = start_slot;
          s_nxt     = '0;
          q_nxt     = '0;
          state_nxt = S_WIN;
        end
      end
      S_WIN: begin
        if (wj_r == fwin_r - 1'b1) begin
          wj_nxt    = '0;
          wi_nxt    = wi_r + 1'b1;
          wslot_nxt = (int'(wslot_r) == MAX_WINDOW - 1) ? '0 : wslot_r + 1'b1;
          if (wi_r == fwin_r - 1'b1) begin
            state_nxt = S_WTAIL;
          end
        end else begin
          wj_nxt = wj_r + 1'b1;
        end
      end
      S_WTAIL: begin
        state_nxt = S_A0;
      end
      S_A0: begin
        nq_nxt    = DW'(n_r) * DW'(q_r);
        state_nxt = S_A1;
      end
      S_A1: begin
        ss_nxt    = DW'(s_r) * DW'(s_r);
        state_nxt = S_A2;
      end
      S_A2: begin
        d_nxt     = nq_r - ss_r;
        anv_nxt   = AW'(fnoise_r) * AW'(n_r);
        state_nxt = S_A3;
      end
      S_A3: begin
        a_nxt     = anv_r * AW'(n_r);
        nc_nxt    = SW'(n_r) * SW'(c_r);
        state_nxt = S_A4;
      end
      S_A4: begin
        b_nxt     = {d_r, 8'd0};
        nb_nxt    = NBW'(n_r) * NBW'({d_r, 8'd0});
        pos_nxt   = (s_r >= nc_r);
        diff_nxt  = (s_r >= nc_r) ? (s_r - nc_r) : (nc_r - s_r);
        state_nxt = S_A5;
      end
      S_A5: begin
        if (div_start) begin
          state_nxt = S_DIVW;
        end else begin
          cnb_nxt   = NUMW'(c_r) * NUMW'(nb_r);
          state_nxt = S_A6;
        end
      end
      S_A6: begin
        adiff_nxt = NUMW'(a_r) * NUMW'(diff_r);
        state_nxt = S_A7;
      end
      S_A7: begin
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          res_nxt   = (div_quo > QW'(PIX_MAX)) ? PIX_MAX : div_quo[PB-1:0];
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = res_r[7:0];
          out_err_nxt   = ferr_r;
          out_last_nxt  = (out_lin_r + 1'b1 >= total_r);
          if (out_lin_r + 1'b1 >= total_r) begin
            active_nxt   = 1'b0;
            col_nxt      = '0;
            orow_nxt     = '0;
            ocol_nxt     = '0;
            in_slot_nxt  = '0;
            out_slot_nxt = '0;
            in_lin_nxt   = '0;
            out_lin_nxt  = '0;
          end else begin
            out_lin_nxt = out_lin_r + 1'b1;
            if (ocol_r + 1'b1 >= fw_r) begin
              ocol_nxt     = '0;
              orow_nxt     = orow_r + 1'b1;
              out_slot_nxt = (int'(out_slot_r) == MAX_WINDOW - 1) ? '0 : out_slot_r + 1'b1;
            end else begin
              ocol_nxt = ocol_r + 1'b1;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
      col_r       <= '0;
      orow_r      <= '0;
      ocol_r      <= '0;
      in_slot_r   <= '0;
      out_slot_r  <= '0;
      in_lin_r    <= '0;
      out_lin_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      rd_v_r      <= (state_r == S_WIN);
      col_r       <= col_nxt;
      orow_r      <= orow_nxt;
      ocol_r      <= ocol_nxt;
      in_slot_r   <= in_slot_nxt;
      out_slot_r  <= out_slot_nxt;
      in_lin_r    <= in_lin_nxt;
      out_lin_r   <= out_lin_nxt;
    end
    flush_r    <= flush_nxt;
    px_r       <= px_nxt;
    fw_r       <= fw_nxt;
    fh_r       <= fh_nxt;
    fwin_r     <= fwin_nxt;
    fhalf_r    <= fhalf_nxt;
    fnoise_r   <= fnoise_nxt;
    ferr_r     <= ferr_nxt;
    n_r        <= n_nxt;
    total_r    <= total_nxt;
    lag_r      <= lag_nxt;
    border_r   <= border_nxt;
    wi_r       <= wi_nxt;
    wj_r       <= wj_nxt;
    wslot_r    <= wslot_nxt;
    s_r        <= s_nxt;
    q_r        <= q_nxt;
    c_r        <= c_nxt;
    nq_r       <= nq_nxt;
    ss_r       <= ss_nxt;
    d_r        <= d_nxt;
    anv_r      <= anv_nxt;
    a_r        <= a_nxt;
    nc_r       <= nc_nxt;
    diff_r     <= diff_nxt;
    pos_r      <= pos_nxt;
    b_r        <= b_nxt;
    nb_r       <= nb_nxt;
    cnb_r      <= cnb_nxt;
    adiff_r    <= adiff_nxt;
    res_r      <= res_nxt;
    out_pix_r  <= out_pix_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_pix_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_err_r;

endmodule

`default_nettype wire

/* hdl/mmse_checker.sv */
// port-level checks for the noise filter top level, attached by bind
// depends on mmse_pkg and mmse_adaptive_noise_filter_unit
`default_nettype none

module mmse_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [7:0]                  out_tdata,
  input wire logic                        out_tlast,
  input wire logic                        cfg_valid,
  input wire logic [mmse_pkg::CFG_AW-1:0] cfg_addr
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // one item at a time: input closes after each transaction
  a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while item in progress");

  // a new result does not appear straight after an input transaction taken with none pending
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared too early");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a register write carries a known index
  a_cfg_known: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> !$isunknown(cfg_addr))
    else $error("unknown register index on write");

endmodule

bind mmse_adaptive_noise_filter_unit mmse_checker u_mmse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_valid  (cfg_valid),
  .cfg_addr   (cfg_addr)
);

`default_nettype wire
